// File: src/sil_pkg.sv
// Shared types, constants and helpers for the sorted insert list core.
// Depends on nothing; every other file in the project but sil_ram refers to it.
package sil_pkg;

	// Store geometry.
	localparam int CAPACITY     = 16;
	localparam int VALUE_BITS   = 32;
	localparam int RESULT_LIMIT = 16;
	localparam int READ_MAX     = (CAPACITY < RESULT_LIMIT) ? CAPACITY : RESULT_LIMIT;
	localparam int ADDR_W       = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);

	// Fixed field widths of the item channels.
	localparam int FIELD_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;

	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic signed [VALUE_BITS-1:0] store_t;
	typedef logic signed [FIELD_W-1:0]    field_t;
	typedef logic [POS_W-1:0]             pos_t;

	// Input item kinds.
	typedef enum logic {
		KIND_INSERT  = 1'b0,
		KIND_READOUT = 1'b1
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_ENTRY    = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Control sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_SINGLE,
		S_RO_RD,
		S_RO_WAIT
	} state_t;

	// Sign-extend or wrap an input value to the stored width.
	function automatic store_t to_store(input field_t v);
		return store_t'(v);
	endfunction

	// Bring a stored value back to the result field width.
	function automatic field_t to_field(input store_t v);
		return field_t'(v);
	endfunction

	// Report a store address as a position, modulo the field range.
	function automatic pos_t to_pos(input addr_t a);
		return pos_t'(a);
	endfunction

endpackage

// File: src/sil_req_if.sv
// Request channel interface: valid/ready handshake carrying one input item.
// Depends on sil_pkg for the field widths.
interface sil_req_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [sil_pkg::FIELD_W-1:0] value;

	modport source (output valid, kind, value, input ready);
	modport sink   (input valid, kind, value, output ready);
endinterface

// File: src/sil_rsp_if.sv
// Result channel interface: valid/ready handshake carrying one result item.
// Depends on sil_pkg for the field widths.
interface sil_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [sil_pkg::STATUS_W-1:0]       status;
	logic signed [sil_pkg::FIELD_W-1:0] entry_value;
	logic [sil_pkg::POS_W-1:0]          position;
	logic                               last;

	modport source (output valid, status, entry_value, position, last, input ready);
	modport sink   (input valid, status, entry_value, position, last, output ready);
endinterface

// File: src/sil_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module sil_ram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/sorted_insert_list_core.sv
// Sorted insert list core: keeps up to CAPACITY signed values in ascending order.
// Insert: entries at or above the value move up one place, top entry first, then the value is
//   written and its result loaded; readout: each entry is read, then loaded; drop, empty: one result.
// Ready returns in the cycle after the last result of an item is loaded; a stalled result holds it.
// Reset clears the state, the entry count and the result valid only; the store needs no clearing pass.
// Depends on sil_pkg, sil_req_if, sil_rsp_if and sil_ram.
module sorted_insert_list_core (
	input  logic          clk,
	input  logic          arst_n,
	sil_req_if.sink       req,
	sil_rsp_if.source     rsp
);

	sil_pkg::state_t  state_q, state_d;
	sil_pkg::cnt_t    count_q;
	sil_pkg::addr_t   idx_q;
	sil_pkg::addr_t   idx_m1;
	sil_pkg::store_t  x_q;
	sil_pkg::status_t single_st_q;

	// Memory port signals.
	logic              rd_en;
	sil_pkg::addr_t    rd_addr;
	logic [sil_pkg::VALUE_BITS-1:0] rd_data;
	logic              wr_en;
	sil_pkg::addr_t    wr_addr;
	sil_pkg::store_t   wr_data;

	// Output register.
	logic              out_valid_q;
	sil_pkg::status_t  out_status_q;
	sil_pkg::field_t   out_value_q;
	sil_pkg::pos_t     out_pos_q;
	logic              out_last_q;

	logic              load;
	sil_pkg::status_t  load_status;
	sil_pkg::field_t   load_value;
	sil_pkg::pos_t     load_pos;
	logic              load_last;

	logic              req_fire;
	logic              can_load;
	logic              rd_ge;
	logic              ro_last;
	sil_pkg::cnt_t     idx_p1;

	assign req_fire = req.valid && req.ready;
	assign can_load = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == sil_pkg::S_IDLE);
	assign idx_m1   = idx_q - sil_pkg::addr_t'(1);
	assign idx_p1   = sil_pkg::cnt_t'(idx_q) + sil_pkg::cnt_t'(1);
	assign rd_ge    = ($signed(rd_data) >= x_q);
	assign ro_last  = (idx_p1 == count_q) || (idx_p1 == sil_pkg::cnt_t'(sil_pkg::READ_MAX));

	// Entry store.
	sil_ram #(
		.W(sil_pkg::VALUE_BITS),
		.D(sil_pkg::CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sil_pkg::S_IDLE: begin
				if (req_fire) begin
					if (req.kind == sil_pkg::KIND_READOUT) begin
						state_d = (count_q == '0) ? sil_pkg::S_SINGLE : sil_pkg::S_RO_RD;
					end else if (count_q == sil_pkg::cnt_t'(sil_pkg::CAPACITY)) begin
						state_d = sil_pkg::S_SINGLE;
					end else begin
						state_d = (count_q == '0) ? sil_pkg::S_INS_PUT : sil_pkg::S_INS_RD;
					end
				end
			end
			sil_pkg::S_INS_RD: begin
				state_d = sil_pkg::S_INS_CMP;
			end
			sil_pkg::S_INS_CMP: begin
				if (rd_ge && idx_m1 != '0) begin
					state_d = sil_pkg::S_INS_RD;
				end else begin
					state_d = sil_pkg::S_INS_PUT;
				end
			end
			sil_pkg::S_INS_PUT, sil_pkg::S_SINGLE: begin
				if (can_load) begin
					state_d = sil_pkg::S_IDLE;
				end
			end
			sil_pkg::S_RO_RD: begin
				state_d = sil_pkg::S_RO_WAIT;
			end
			sil_pkg::S_RO_WAIT: begin
				if (can_load) begin
					state_d = ro_last ? sil_pkg::S_IDLE : sil_pkg::S_RO_RD;
				end
			end
			default: begin
				state_d = sil_pkg::S_IDLE;
			end
		endcase
	end

	// Memory accesses and result loading per state.
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = idx_q;
		wr_en       = 1'b0;
		wr_addr     = idx_q;
		wr_data     = x_q;
		load        = 1'b0;
		load_status = sil_pkg::ST_ENTRY;
		load_value  = sil_pkg::to_field($signed(rd_data));
		load_pos    = sil_pkg::to_pos(idx_q);
		load_last   = 1'b1;
		unique case (state_q)
			sil_pkg::S_INS_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_m1;
			end
			sil_pkg::S_INS_CMP: begin
				// Entries at or above the new value move up one place.
				wr_en   = rd_ge;
				wr_data = $signed(rd_data);
			end
			sil_pkg::S_INS_PUT: begin
				wr_en       = can_load;
				load        = can_load;
				load_status = sil_pkg::ST_INSERTED;
				load_value  = sil_pkg::to_field(x_q);
			end
			sil_pkg::S_SINGLE: begin
				load        = can_load;
				load_status = single_st_q;
				load_value  = sil_pkg::to_field(x_q);
				load_pos    = '0;
			end
			sil_pkg::S_RO_RD: begin
				rd_en = 1'b1;
			end
			sil_pkg::S_RO_WAIT: begin
				load      = can_load;
				load_last = ro_last;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sil_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sil_pkg::S_INS_PUT && can_load) begin
				count_q <= count_q + sil_pkg::cnt_t'(1);
			end
		end
	end

	// Item working registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			if (req.kind == sil_pkg::KIND_READOUT) begin
				x_q         <= '0;
				idx_q       <= '0;
				single_st_q <= sil_pkg::ST_EMPTY;
			end else begin
				x_q         <= sil_pkg::to_store(req.value);
				idx_q       <= sil_pkg::addr_t'(count_q);
				single_st_q <= sil_pkg::ST_DROPPED;
			end
		end else if (state_q == sil_pkg::S_INS_CMP && rd_ge) begin
			idx_q <= idx_m1;
		end else if (state_q == sil_pkg::S_RO_WAIT && can_load) begin
			idx_q <= idx_q + sil_pkg::addr_t'(1);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= load_status;
			out_value_q  <= load_value;
			out_pos_q    <= load_pos;
			out_last_q   <= load_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.position    = out_pos_q;
	assign rsp.last        = out_last_q;

	// The entry count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sil_pkg::cnt_t'(sil_pkg::CAPACITY))
		else $error("entry count above capacity");

	// A readout only reads filled entries.
	a_ro_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sil_pkg::S_RO_RD) |-> (sil_pkg::cnt_t'(idx_q) < count_q))
		else $error("readout beyond filled entries");

	// Stores never reach past one above the filled region.
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (sil_pkg::cnt_t'(wr_addr) <= count_q))
		else $error("store write outside list");

	// A completed insert grows the list by exactly one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sil_pkg::S_INS_PUT && can_load)
		|=> (count_q == $past(count_q) + sil_pkg::cnt_t'(1)))
		else $error("insert did not grow the list");

	// Input items are taken only while the sequencer is idle with no store access.
	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> (!rd_en && !wr_en && !load))
		else $error("item accepted during list work");

endmodule

// File: tb/sorted_insert_list_core_tb.sv
// Self-checking testbench for sorted_insert_list_core: a shadow list predicts every result item.
// Drives the request channel and checks the result channel under random and forced stalls.
// Depends on sil_pkg, sil_req_if, sil_rsp_if and the core itself.
module sorted_insert_list_core_tb;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 6;
	localparam int HOLD_CYCLES  = 150;
	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		sil_pkg::kind_t  kind;
		sil_pkg::field_t value;
	} list_cmd_t;

	typedef struct {
		sil_pkg::status_t status;
		sil_pkg::field_t  entry_value;
		sil_pkg::pos_t    position;
		logic             last;
	} list_result_t;

	logic clk;
	logic arst_n;

	sil_req_if req_ch ();
	sil_rsp_if rsp_ch ();

	sorted_insert_list_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Commands waiting to be offered, and results the shadow list says are due.
	list_cmd_t    cmds_to_send[$];
	list_result_t results_due[$];

	// Shadow copy of the sorted store.
	sil_pkg::store_t shadow_list[sil_pkg::CAPACITY];
	int              shadow_len;

	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_trigger;
	int  hold_seen;
	int  hold_left;
	bit  cmd_taken;
	int  fail_count;
	int  inserts_taken;
	int  drops_due;
	int  readouts_taken;
	int  results_checked;
	int  quiet_cycles;

	// Clock.
	always #(HALF_PERIOD) clk = ~clk;

	// Apply one accepted command to the shadow list and queue its results.
	function automatic void apply_to_shadow_list(input sil_pkg::kind_t kind,
			input sil_pkg::field_t value);
		sil_pkg::store_t x;
		int              slot;
		int              n;
		list_result_t    r;
		x = sil_pkg::store_t'(value);
		if (kind == sil_pkg::KIND_INSERT) begin
			inserts_taken++;
			r.last = 1'b1;
			if (shadow_len >= sil_pkg::CAPACITY) begin
				// Full list: the value is dropped and flagged.
				drops_due++;
				r.status      = sil_pkg::ST_DROPPED;
				r.entry_value = sil_pkg::field_t'(x);
				r.position    = '0;
			end else begin
				// The new value goes ahead of any equal values already stored.
				slot = 0;
				while (slot < shadow_len && shadow_list[slot] < x)
					slot++;
				for (int i = shadow_len; i > slot; i--)
					shadow_list[i] = shadow_list[i-1];
				shadow_list[slot] = x;
				shadow_len++;
				r.status      = sil_pkg::ST_INSERTED;
				r.entry_value = sil_pkg::field_t'(x);
				r.position    = sil_pkg::pos_t'(slot);
			end
			results_due.push_back(r);
		end else begin
			readouts_taken++;
			n = (shadow_len < sil_pkg::READ_MAX) ? shadow_len : sil_pkg::READ_MAX;
			if (n == 0) begin
				r.status      = sil_pkg::ST_EMPTY;
				r.entry_value = '0;
				r.position    = '0;
				r.last        = 1'b1;
				results_due.push_back(r);
			end else begin
				for (int i = 0; i < n; i++) begin
					r.status      = sil_pkg::ST_ENTRY;
					r.entry_value = sil_pkg::field_t'(shadow_list[i]);
					r.position    = sil_pkg::pos_t'(i);
					r.last        = (i == n - 1);
					results_due.push_back(r);
				end
			end
		end
	endfunction

	// Random value biased toward the extremes and toward small, often equal values.
	function automatic sil_pkg::field_t pick_value();
		sil_pkg::field_t v;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh7fff_ffff;
					1: v = 32'sh8000_0000;
					2: v = '0;
					3: v = -32'sd1;
					default: v = 32'sd1;
				endcase
			end
			1: v = sil_pkg::field_t'($urandom_range(0, 40)) - 32'sd20;
			default: v = sil_pkg::field_t'($urandom);
		endcase
		return v;
	endfunction

	function automatic void queue_cmd(input sil_pkg::kind_t kind, input sil_pkg::field_t value);
		list_cmd_t c;
		c.kind  = kind;
		c.value = value;
		cmds_to_send.push_back(c);
	endfunction

	function automatic void queue_random_cmds(input int count);
		for (int i = 0; i < count; i++)
			queue_cmd(($urandom_range(0, 3) == 0) ? sil_pkg::KIND_READOUT : sil_pkg::KIND_INSERT,
				pick_value());
	endfunction

	// Wait until everything queued has been sent and every result has arrived.
	task automatic wait_drained();
		while (cmds_to_send.size() != 0 || req_ch.valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	// Request driver: from the falling edge after the last item was taken, a new one is offered unless the sender idles.
	always @(negedge clk) begin
		list_cmd_t next_cmd;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || cmd_taken) begin
			if (cmds_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_cmd = cmds_to_send.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.kind  <= next_cmd.kind;
				req_ch.value <= next_cmd.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Accepted requests feed the shadow list.
	always @(posedge clk) begin
		cmd_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready)
			apply_to_shadow_list(sil_pkg::kind_t'(req_ch.kind), req_ch.value);
	end

	// Result ready: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_left == 0 && hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Result monitor: each accepted result is checked against the oldest one due.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (results_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("ERROR: unexpected result status=%0d value=%0d pos=%0d last=%0b",
						rsp_ch.status, rsp_ch.entry_value, rsp_ch.position, rsp_ch.last);
			end else begin
				want = results_due.pop_front();
				results_checked++;
				if (rsp_ch.status !== want.status || rsp_ch.entry_value !== want.entry_value ||
				    rsp_ch.position !== want.position || rsp_ch.last !== want.last) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"ERROR: result mismatch: expected status=%0d value=%0d ",
							"pos=%0d last=%0b, got status=%0d value=%0d pos=%0d last=%0b"},
							want.status, want.entry_value, want.position, want.last,
							rsp_ch.status, rsp_ch.entry_value, rsp_ch.position, rsp_ch.last);
				end
			end
		end
	end

	// Watchdog: too long without any item moving on either channel ends the run.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
				$display("sorted_insert_list_core_tb failed");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.kind     = sil_pkg::KIND_INSERT;
		req_ch.value    = '0;
		rsp_ch.ready    = 1'b0;
		cmd_taken       = 1'b0;
		shadow_len      = 0;
		hold_trigger    = 0;
		hold_seen       = 0;
		hold_left       = 0;
		fail_count      = 0;
		inserts_taken   = 0;
		drops_due       = 0;
		readouts_taken  = 0;
		results_checked = 0;
		quiet_cycles    = 0;
		send_idle_pct   = 34;
		recv_idle_pct   = 60;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty readout, extremes, equal values, a full list, drops.
		queue_cmd(sil_pkg::KIND_READOUT, 32'sd12345);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd0);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sh7fff_ffff);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sh8000_0000);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd0);
		queue_cmd(sil_pkg::KIND_INSERT, -32'sd1);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd1);
		queue_cmd(sil_pkg::KIND_READOUT, -32'sd1);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd0);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sh8000_0000);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sh7fff_ffff);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd5);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd4);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd3);
		queue_cmd(sil_pkg::KIND_INSERT, -32'sd5);
		queue_cmd(sil_pkg::KIND_INSERT, -32'sd4);
		queue_cmd(sil_pkg::KIND_INSERT, -32'sd3);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd100);
		queue_cmd(sil_pkg::KIND_READOUT, 32'sh7fff_ffff);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sd7);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sh7fff_ffff);
		queue_cmd(sil_pkg::KIND_INSERT, 32'sh8000_0000);
		queue_cmd(sil_pkg::KIND_READOUT, 32'sh8000_0000);
		wait_drained();

		// Random, slow receiver; the receiver holds off long enough to back up the core.
		queue_random_cmds(130);
		hold_trigger++;
		wait_drained();

		// Random, slow sender.
		send_idle_pct = 60;
		recv_idle_pct = 34;
		queue_random_cmds(130);
		wait_drained();

		// Random, no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_cmds(140);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (results_due.size() != 0) begin
			fail_count += results_due.size();
			$display("ERROR: %0d results never arrived", results_due.size());
		end

		$display("Run covered %0d inserts (%0d dropped on a full list) and %0d readouts.",
			inserts_taken, drops_due, readouts_taken);
		$display("%0d result items checked, %0d errors.", results_checked, fail_count);
		if (fail_count == 0) begin
			$display("sorted_insert_list_core_tb passed");
		end else begin
			$display("sorted_insert_list_core_tb failed");
		end
		$finish;
	end

endmodule
